// ----- sv/set_assoc_lru_cache_sim_core_macros.svh -----
// Assertion macros used by the core module to check its own logic.
`ifndef SET_ASSOC_LRU_CACHE_SIM_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_CORE_MACROS_SVH

// Checked on every clock edge outside reset.
`define SALC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SALC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/salc_pkg.sv -----
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int TAG_W            = 32;
    localparam int WAYS_W           = 4;
    localparam int PADDR_W          = 4;
    localparam int PDATA_W          = 32;

    localparam logic [2:0] SET_BITS_RST   = 3'd1;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd1;
    localparam logic [3:0] WAYS_RST       = 4'd1;

    typedef enum logic [1:0] {
        REG_SET_BITS   = 2'd0,
        REG_BLOCK_BITS = 2'd1,
        REG_WAYS       = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_STORE  = 2'd1,
        FUNC_MODIFY = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

endpackage

// ----- sv/set_assoc_lru_cache_sim_core.sv -----
// Set-associative cache model with LRU replacement. Each item is a load, store or modify
// access; loads and stores give one result, a modify gives two (the second carries last),
// and func 3 is taken and gives nothing. The block handles one item at a time. After
// reset it clears every row of the set memory (2**MAX_SET_BITS rows, 64 at the default) and
// takes no item meanwhile. Let w be the way count in use: ways_in_use, with 0 read as 1
// and values above MAX_WAYS read as MAX_WAYS. An access reads the set, then scans w ways,
// one way per cycle through the single tag comparator, then writes the row back, and then
// holds its result until it is taken; a modify runs two such accesses in a row. The block
// returns to idle after the last result is taken and only there accepts the next item.
// The user must write the configuration registers over the APB port only while idle; the
// block itself does not enforce this.
`include "set_assoc_lru_cache_sim_core_macros.svh"

module set_assoc_lru_cache_sim_core #(
    parameter int MAX_SET_BITS = salc_pkg::MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = salc_pkg::MAX_WAYS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [salc_pkg::PADDR_W-1:0] paddr,
    input  logic [salc_pkg::PDATA_W-1:0] pwdata,
    output logic [salc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   func,
    input  logic [31:0]                  address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [1:0]                   outcome,
    output logic [2:0]                   way_used,
    output logic [5:0]                   set_used,
    output logic [31:0]                  hits_total,
    output logic [31:0]                  misses_total,
    output logic [31:0]                  evictions_total,
    output logic                         last
);
    import salc_pkg::*;

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int AGE_MAX  = MAX_WAYS - 1;
    localparam int ROW_W    = MAX_WAYS * (TAG_W + AGE_W + 1);

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // Configuration registers.
    logic [2:0] set_bits_reg;
    logic [4:0] block_bits_reg;
    logic [3:0] ways_in_use_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= SET_BITS_RST;
            block_bits_reg  <= BLOCK_BITS_RST;
            ways_in_use_reg <= WAYS_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_SET_BITS:   set_bits_reg    <= pwdata[2:0];
                REG_BLOCK_BITS: block_bits_reg  <= pwdata[4:0];
                REG_WAYS:       ways_in_use_reg <= pwdata[3:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_SET_BITS:   prdata = 32'(set_bits_reg);
            REG_BLOCK_BITS: prdata = 32'(block_bits_reg);
            REG_WAYS:       prdata = 32'(ways_in_use_reg);
            default:        prdata = '0;
        endcase
    end

    // Address split and effective way count.
    logic [2:0]       s_eff;
    logic [5:0]       sb;
    logic [31:0]      shifted;
    logic [SET_W-1:0] set_mask;
    logic [SET_W-1:0] set_in;
    logic [TAG_W-1:0] tag_in;
    logic [3:0]       ways_eff;

    always_comb
    begin
        s_eff    = (int'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;
        sb       = 6'(s_eff) + 6'(block_bits_reg);
        tag_in   = (sb >= 6'd32) ? '0 : (address >> sb);
        shifted  = address >> block_bits_reg;
        set_mask = ~({SET_W{1'b1}} << s_eff);
        set_in   = SET_W'(shifted) & set_mask;
        if (ways_in_use_reg == 4'd0)
        begin
            ways_eff = 4'd1;
        end
        else if (int'(ways_in_use_reg) > MAX_WAYS)
        begin
            ways_eff = 4'(MAX_WAYS);
        end
        else
        begin
            ways_eff = ways_in_use_reg;
        end
    end

    // Sequencer state and item registers.
    state_t           state_reg, state_next;
    logic [SET_W-1:0] clr_cnt_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             second_reg;
    logic [31:0]      hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;

    logic [1:0]       outcome_reg;
    logic [WAY_W-1:0] way_reg;

    // Set memory and scan unit.
    logic                            mem_we, mem_re;
    logic [SET_W-1:0]                mem_waddr;
    logic [ROW_W-1:0]                mem_wdata, mem_rdata;
    logic [MAX_WAYS-1:0]             row_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  row_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  row_age;
    logic [MAX_WAYS-1:0]             new_valid;
    logic [MAX_WAYS-1:0][TAG_W-1:0]  new_tag;
    logic [MAX_WAYS-1:0][AGE_W-1:0]  new_age;

    scan_ctl_t        scan_ctl;
    logic             scan_done, scan_hit, scan_empty;
    logic [WAY_W-1:0] scan_hit_way, scan_empty_way, scan_best_way;

    assign {row_age, row_tag, row_valid} = mem_rdata;

    salc_set_ram #(
        .ADDR_W (SET_W),
        .ROW_W  (ROW_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (set_reg),
        .rdata (mem_rdata)
    );

    salc_way_scan #(
        .MAX_WAYS (MAX_WAYS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .ways      (ways_eff),
        .tag       (tag_reg),
        .row_valid (row_valid),
        .row_tag   (row_tag),
        .row_age   (row_age),
        .done      (scan_done),
        .hit       (scan_hit),
        .hit_way   (scan_hit_way),
        .empty     (scan_empty),
        .empty_way (scan_empty_way),
        .best_way  (scan_best_way)
    );

    // Victim choice and the new row after the access.
    logic [WAY_W-1:0] way_sel;
    outcome_t         outcome_sel;
    logic             was_valid;
    logic [AGE_W-1:0] own_age;

    always_comb
    begin
        if (scan_hit)
        begin
            way_sel     = scan_hit_way;
            outcome_sel = OUT_HIT;
        end
        else if (scan_empty)
        begin
            way_sel     = scan_empty_way;
            outcome_sel = OUT_FILL;
        end
        else
        begin
            way_sel     = scan_best_way;
            outcome_sel = OUT_EVICT;
        end
        was_valid = row_valid[way_sel];
        own_age   = row_age[way_sel];
        new_valid = row_valid;
        new_tag   = row_tag;
        new_age   = row_age;
        for (int k = 0; k < MAX_WAYS; k++)
        begin
            if (k < int'(ways_eff) && k != int'(way_sel) && row_valid[k]
                && (!was_valid || row_age[k] < own_age)
                && row_age[k] < AGE_W'(AGE_MAX))
            begin
                new_age[k] = row_age[k] + 1'b1;
            end
        end
        new_valid[way_sel] = 1'b1;
        new_tag[way_sel]   = tag_reg;
        new_age[way_sel]   = '0;
    end

    // Sequencer.
    logic accept, start_item, clr_last, out_fire;

    assign accept     = in_valid && in_ready;
    assign start_item = accept && (func != 2'd3);
    assign clr_last   = (clr_cnt_reg == SET_W'(NUM_SETS - 1));
    assign out_fire   = out_valid && out_ready;

    always_comb
    begin
        state_next     = state_reg;
        scan_ctl.start = 1'b0;
        scan_ctl.step  = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = set_reg;
        mem_wdata      = {new_age, new_tag, new_valid};
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (start_item)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_re         = 1'b1;
                scan_ctl.start = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_ctl.step = 1'b1;
                if (scan_done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                mem_we     = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = second_reg ? ST_READ : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            second_reg    <= 1'b0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (start_item)
            begin
                second_reg <= (func_t'(func) == FUNC_MODIFY);
            end
            else if (out_fire)
            begin
                second_reg <= 1'b0;
            end
            if (state_reg == ST_UPDATE)
            begin
                if (outcome_sel == OUT_HIT)
                begin
                    hit_cnt_reg <= sat_inc(hit_cnt_reg);
                end
                else
                begin
                    miss_cnt_reg <= sat_inc(miss_cnt_reg);
                end
                if (outcome_sel == OUT_EVICT)
                begin
                    evict_cnt_reg <= sat_inc(evict_cnt_reg);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_item)
        begin
            set_reg <= set_in;
            tag_reg <= tag_in;
        end
        if (state_reg == ST_UPDATE)
        begin
            outcome_reg <= outcome_sel;
            way_reg     <= way_sel;
        end
    end

    assign outcome         = outcome_reg;
    assign way_used        = 3'(way_reg);
    assign set_used        = 6'(set_reg);
    assign hits_total      = hit_cnt_reg;
    assign misses_total    = miss_cnt_reg;
    assign evictions_total = evict_cnt_reg;
    assign last            = !second_reg;

    `SALC_ASSERT_ALWAYS(a_no_overlap, !(in_ready && out_valid), "ready while result pending")
    `SALC_ASSERT(a_second_follows, (out_fire && !last) |=> !in_ready, "second access lost")
    `SALC_ASSERT(a_evict_le_miss, out_valid |-> evictions_total <= misses_total, "evictions high")
    `SALC_ASSERT(a_hit_count, out_valid && outcome == OUT_HIT |-> hits_total != '0, "hit uncounted")

endmodule

// ----- sv/salc_set_ram.sv -----
module salc_set_ram #(
    parameter int ADDR_W = 6,
    parameter int ROW_W  = 288
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [ROW_W-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [ROW_W-1:0]  rdata
);

    logic [ROW_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/salc_way_scan.sv -----
module salc_way_scan #(
    parameter int MAX_WAYS = 8,
    localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  salc_pkg::scan_ctl_t                    ctl,
    input  logic [salc_pkg::WAYS_W-1:0]            ways,
    input  logic [salc_pkg::TAG_W-1:0]             tag,
    input  logic [MAX_WAYS-1:0]                    row_valid,
    input  logic [MAX_WAYS-1:0][salc_pkg::TAG_W-1:0] row_tag,
    input  logic [MAX_WAYS-1:0][AGE_W-1:0]         row_age,
    output logic                                   done,
    output logic                                   hit,
    output logic [WAY_W-1:0]                       hit_way,
    output logic                                   empty,
    output logic [WAY_W-1:0]                       empty_way,
    output logic [WAY_W-1:0]                       best_way
);
    import salc_pkg::*;

    logic [WAY_W-1:0] idx_reg;
    logic             hit_reg;
    logic             empty_reg;
    logic [WAY_W-1:0] hit_way_reg;
    logic [WAY_W-1:0] empty_way_reg;
    logic [WAY_W-1:0] best_way_reg;
    logic [AGE_W-1:0] best_age_reg;

    logic             cur_valid;
    logic [TAG_W-1:0] cur_tag;
    logic [AGE_W-1:0] cur_age;

    // One way is examined per cycle through a single tag comparator.
    assign cur_valid = row_valid[idx_reg];
    assign cur_tag   = row_tag[idx_reg];
    assign cur_age   = row_age[idx_reg];

    assign done = ctl.step && ((5'(idx_reg) + 5'd1) == 5'(ways));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            idx_reg   <= '0;
            hit_reg   <= 1'b0;
            empty_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (!hit_reg && cur_valid && (cur_tag == tag))
            begin
                hit_reg <= 1'b1;
            end
            if (!empty_reg && !cur_valid)
            begin
                empty_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            best_way_reg <= '0;
            best_age_reg <= '0;
        end
        else if (ctl.step)
        begin
            if (!hit_reg && cur_valid && (cur_tag == tag))
            begin
                hit_way_reg <= idx_reg;
            end
            if (!empty_reg && !cur_valid)
            begin
                empty_way_reg <= idx_reg;
            end
            // Strictly greater keeps the lowest way among equal ages.
            if (cur_age > best_age_reg)
            begin
                best_way_reg <= idx_reg;
                best_age_reg <= cur_age;
            end
        end
    end

    assign hit       = hit_reg;
    assign hit_way   = hit_way_reg;
    assign empty     = empty_reg;
    assign empty_way = empty_way_reg;
    assign best_way  = best_way_reg;

endmodule
